>>> design/bsa_pkg.sv
// Shared constants, codes and word types for the bitmap slot allocator.
// No dependencies; every other file of the block but bsa_ram takes names from here.
`timescale 1ns / 1ps

package bsa_pkg;

   localparam int CAPACITY  = 1024;
   localparam int WORD_BITS = 32;
   localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
   localparam int WORD_AW   = $clog2(NUM_WORDS);
   localparam int BIT_AW    = $clog2(WORD_BITS);
   localparam int IDX_W     = 10;
   localparam int CNT_W     = 11;

   typedef enum logic [1:0] {
      ACT_ALLOC   = 2'd0,
      ACT_FREE    = 2'd1,
      ACT_RESERVE = 2'd2,
      ACT_NOP     = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      action_type       action;
      logic [IDX_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [IDX_W-1:0] granted_index;
      logic [CNT_W-1:0] free_count;
      logic [CNT_W-1:0] used_count;
   } rsp_type;

   // Saturate a programmed size to the built capacity.
   function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] size);
      logic [CNT_W-1:0] cap;
      cap = CNT_W'(CAPACITY);
      return (size > cap) ? cap : size;
   endfunction

endpackage

>>> design/bsa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule

>>> design/bsa_scan.sv
// Lowest-free-bit finder for one bitmap word; bits at or above the size count as used.
// Depends on bsa_pkg.
`timescale 1ns / 1ps

module bsa_scan (
   input  logic [bsa_pkg::WORD_BITS-1:0] word_data,
   input  logic [bsa_pkg::WORD_AW-1:0]   word_num,
   input  logic [bsa_pkg::CNT_W-1:0]     size_eff,
   output logic                          hit,
   output logic [bsa_pkg::BIT_AW-1:0]    hit_pos
);

   // Walk down from the top so the lowest free slot is the one left standing.
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int b = bsa_pkg::WORD_BITS - 1; b >= 0; b--) begin
         if (!word_data[b] &&
             (bsa_pkg::CNT_W'({word_num, bsa_pkg::BIT_AW'(b)}) < size_eff)) begin
            hit     = 1'b1;
            hit_pos = bsa_pkg::BIT_AW'(b);
         end
      end
   end

endmodule

>>> design/bitmap_slot_allocator.sv
// Top level of the bitmap first-fit slot allocator.
// Depends on bsa_pkg, bsa_ram and bsa_scan.
`timescale 1ns / 1ps

// Bitmap slot allocator. One bit per slot (1 = used) is held in a 32 x 32-bit
// RAM, beside a free-slot count. Issue a request word by raising start while
// busy is low; exactly one response word follows, on rsp_word for a single
// cycle with rsp_strobe high. The receiver cannot stall: take the word when
// the strobe is seen. A no-op, an out-of-range free or reserve, and an
// allocate when nothing is free are answered at once with no RAM access;
// free and reserve do one RAM read, then modify and write back; allocate
// scans the bitmap words from word 0 up to the word holding the lowest free
// slot. The scan reads one word per cycle through the single RAM read port.
// The response appears in the cycle after the item completes. Writing
// csr_wr_data (with csr_wr_en) sets the managed size (saturated to 1024),
// frees every slot and reloads the free count at once; write it only while
// no request is outstanding. Reset does the same with a size of 1024. A
// per-word valid bit marks words written since the last clear, so no
// clearing pass is needed.
module bitmap_slot_allocator (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  bsa_pkg::req_type            req_word,
   output logic                        rsp_strobe,
   output bsa_pkg::rsp_type            rsp_word,
   input  logic                        csr_wr_en,
   input  logic [bsa_pkg::CNT_W-1:0]   csr_wr_data
);

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_LOOK = 2'b10
   } state_type;

   state_type                        state_ff, state_in;
   logic [bsa_pkg::CNT_W-1:0]        size_ff;
   logic [bsa_pkg::CNT_W-1:0]        free_ff, free_in;
   logic [bsa_pkg::NUM_WORDS-1:0]    valid_ff;
   logic                             rd_valid_ff, rd_valid_in;
   bsa_pkg::action_type              act_ff, act_in;
   logic [bsa_pkg::IDX_W-1:0]        idx_ff, idx_in;
   logic [bsa_pkg::WORD_AW-1:0]      cur_ff, cur_in;
   logic                             rsp_strobe_ff, rsp_strobe_in;
   bsa_pkg::rsp_type                 rsp_word_ff, rsp_word_in;

   logic                             ram_we, ram_re;
   logic [bsa_pkg::WORD_AW-1:0]      ram_waddr, ram_raddr;
   logic [bsa_pkg::WORD_BITS-1:0]    ram_wdata, ram_rdata, word_eff;
   logic                             scan_hit;
   logic [bsa_pkg::BIT_AW-1:0]       scan_pos;
   logic [bsa_pkg::CNT_W-1:0]        size_eff;
   logic                             accept, range_err, cur_bit;
   logic [bsa_pkg::BIT_AW-1:0]       idx_bit;

   assign size_eff   = bsa_pkg::eff_size(size_ff);
   assign busy       = (state_ff == S_LOOK);
   assign accept     = start && !busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

   // A word never written since the last clear reads as all free.
   assign word_eff = rd_valid_ff ? ram_rdata : '0;
   assign idx_bit  = idx_ff[bsa_pkg::BIT_AW-1:0];
   assign cur_bit  = word_eff[idx_bit];

   assign range_err = (req_word.action inside {bsa_pkg::ACT_FREE, bsa_pkg::ACT_RESERVE}) &&
                      (bsa_pkg::CNT_W'(req_word.slot_index) >= size_eff);

   bsa_ram #(
      .WIDTH (bsa_pkg::WORD_BITS),
      .DEPTH (bsa_pkg::NUM_WORDS)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   bsa_scan u_scan (
      .word_data (word_eff),
      .word_num  (cur_ff),
      .size_eff  (size_eff),
      .hit       (scan_hit),
      .hit_pos   (scan_pos)
   );

   always_comb begin
      state_in      = state_ff;
      free_in       = free_ff;
      act_in        = act_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      ram_we        = 1'b0;
      ram_waddr     = cur_ff;
      ram_wdata     = word_eff;
      ram_re        = 1'b0;
      ram_raddr     = cur_ff;
      rd_valid_in   = rd_valid_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               act_in = req_word.action;
               idx_in = req_word.slot_index;
               if (req_word.action == bsa_pkg::ACT_NOP || range_err ||
                   (req_word.action == bsa_pkg::ACT_ALLOC && free_ff == '0)) begin
                  // Answer at once: nothing to read or change.
                  rsp_strobe_in             = 1'b1;
                  rsp_word_in.granted_index = '0;
                  if (range_err) begin
                     rsp_word_in.status = bsa_pkg::STS_RANGE;
                  end else if (req_word.action == bsa_pkg::ACT_ALLOC) begin
                     rsp_word_in.status = bsa_pkg::STS_FULL;
                  end else begin
                     rsp_word_in.status = bsa_pkg::STS_DONE;
                  end
               end else begin
                  // Fetch the first word to scan, or the word holding the slot.
                  ram_re = 1'b1;
                  if (req_word.action == bsa_pkg::ACT_ALLOC) begin
                     ram_raddr = '0;
                  end else begin
                     ram_raddr = req_word.slot_index[bsa_pkg::IDX_W-1:bsa_pkg::BIT_AW];
                  end
                  cur_in   = ram_raddr;
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            if (act_ff == bsa_pkg::ACT_ALLOC) begin
               if (scan_hit) begin
                  ram_we                    = 1'b1;
                  ram_wdata                 = word_eff |
                                              (bsa_pkg::WORD_BITS'(1) << scan_pos);
                  free_in                   = free_ff - bsa_pkg::CNT_W'(1);
                  rsp_strobe_in             = 1'b1;
                  rsp_word_in.status        = bsa_pkg::STS_DONE;
                  rsp_word_in.granted_index = {cur_ff, scan_pos};
                  state_in                  = S_IDLE;
               end else if (cur_ff == bsa_pkg::WORD_AW'(bsa_pkg::NUM_WORDS - 1)) begin
                  rsp_strobe_in             = 1'b1;
                  rsp_word_in.status        = bsa_pkg::STS_FULL;
                  rsp_word_in.granted_index = '0;
                  state_in                  = S_IDLE;
               end else begin
                  // Advance the scan by one word; the read of the next word is issued now.
                  ram_re    = 1'b1;
                  ram_raddr = cur_ff + bsa_pkg::WORD_AW'(1);
                  cur_in    = ram_raddr;
               end
            end else begin
               // Free or reserve: write back only when the bit really flips.
               if (act_ff == bsa_pkg::ACT_FREE && cur_bit) begin
                  ram_we    = 1'b1;
                  ram_wdata = word_eff & ~(bsa_pkg::WORD_BITS'(1) << idx_bit);
                  free_in   = free_ff + bsa_pkg::CNT_W'(1);
               end else if (act_ff == bsa_pkg::ACT_RESERVE && !cur_bit) begin
                  ram_we    = 1'b1;
                  ram_wdata = word_eff | (bsa_pkg::WORD_BITS'(1) << idx_bit);
                  free_in   = free_ff - bsa_pkg::CNT_W'(1);
               end
               rsp_strobe_in             = 1'b1;
               rsp_word_in.status        = bsa_pkg::STS_DONE;
               rsp_word_in.granted_index = '0;
               state_in                  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (ram_re) begin
         rd_valid_in = valid_ff[ram_raddr];
      end

      // Counts always report the state after this request.
      rsp_word_in.free_count = free_in;
      rsp_word_in.used_count = size_eff - free_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         size_ff       <= bsa_pkg::CNT_W'(bsa_pkg::CAPACITY);
         free_ff       <= bsa_pkg::CNT_W'(bsa_pkg::CAPACITY);
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_wr_en) begin
            // New size: drop every allocation and reload the count.
            size_ff  <= csr_wr_data;
            free_ff  <= bsa_pkg::eff_size(csr_wr_data);
            valid_ff <= '0;
         end else begin
            free_ff <= free_in;
            if (ram_we) begin
               valid_ff[ram_waddr] <= 1'b1;
            end
         end
      end
   end

   // Payload registers: no reset needed.
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      idx_ff      <= idx_in;
      cur_ff      <= cur_in;
      rd_valid_ff <= rd_valid_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

>>> design/bsa_chk.sv
// Port-level checker for the bitmap slot allocator, bound to the top level.
// Depends on bsa_pkg and on bitmap_slot_allocator.
`timescale 1ns / 1ps

module bsa_chk (
   input logic                      clock,
   input logic                      reset,
   input logic                      start,
   input logic                      busy,
   input logic                      rsp_strobe,
   input bsa_pkg::rsp_type          rsp_word,
   input logic                      csr_wr_en,
   input logic [bsa_pkg::CNT_W-1:0] csr_wr_data
);

   logic [bsa_pkg::CNT_W-1:0] size_ff, size_in;

   assign size_in = csr_wr_en ? bsa_pkg::eff_size(csr_wr_data) : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= bsa_pkg::CNT_W'(bsa_pkg::CAPACITY);
      end else begin
         size_ff <= size_in;
      end
   end

   // Free and used counts always add up to the managed size.
   a_count_sum: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_word.free_count + rsp_word.used_count) == size_ff)
      else $error("free and used counts do not add up to the size");

   // Only a successful request carries a granted index.
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != bsa_pkg::STS_DONE) |-> rsp_word.granted_index == '0)
      else $error("granted index set on a failed request");

   // An accepted request either answers next cycle or holds busy.
   a_accept_prog: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request neither answered nor in progress");

   // A granted slot lies below the managed size.
   a_grant_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status == bsa_pkg::STS_DONE) |->
         bsa_pkg::CNT_W'(rsp_word.granted_index) < size_ff || rsp_word.granted_index == '0)
      else $error("granted index beyond the managed size");

endmodule

bind bitmap_slot_allocator bsa_chk u_bsa_chk (
   .clock       (clock),
   .reset       (reset),
   .start       (start),
   .busy        (busy),
   .rsp_strobe  (rsp_strobe),
   .rsp_word    (rsp_word),
   .csr_wr_en   (csr_wr_en),
   .csr_wr_data (csr_wr_data)
);
